FILE: sv/rrs_pkg.sv
package rrs_pkg;

  localparam int DEF_TASK_SLOTS = 16;
  localparam int DEF_SLEEP_BITS = 32;

  // slot states
  localparam logic [2:0] ST_EMPTY    = 3'd0;
  localparam logic [2:0] ST_READY    = 3'd2;
  localparam logic [2:0] ST_RUNNING  = 3'd3;
  localparam logic [2:0] ST_BLOCKED  = 3'd4;
  localparam logic [2:0] ST_SLEEPING = 3'd5;
  localparam logic [2:0] ST_WAITING  = 3'd6;
  localparam logic [2:0] ST_KILLED   = 3'd7;

  // operations
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_BLOCK   = 3'd2;
  localparam logic [2:0] OP_SLEEP   = 3'd3;
  localparam logic [2:0] OP_UNBLOCK = 3'd4;
  localparam logic [2:0] OP_KILL    = 3'd5;
  localparam logic [2:0] OP_REAP    = 3'd6;

  // result status
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_NOSLOT = 2'd1;
  localparam logic [1:0] STS_BADIDX = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_QUANTUM  = 2'd1;
  localparam logic [1:0] CFG_TURNOVER = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  task_index;
    logic [31:0] sleep_ticks;
  } in_t;

  typedef struct packed {
    logic [3:0] running_task;
    logic       switched;
    logic [3:0] created_task;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] quantum_ticks;
    logic [7:0]  turnover_rounds;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_QRD,
    S_QWR,
    S_CSCAN,
    S_RD,
    S_WR,
    S_RSCAN,
    S_RS0,
    S_RS0W,
    S_DONE
  } fsm_t;

endpackage

FILE: sv/rrs_mem.sv
module rrs_mem
  import rrs_pkg::*;
#(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS,
  parameter int EW         = DEF_SLEEP_BITS + 11,
  localparam int SW        = $clog2(TASK_SLOTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [SW-1:0] rd_addr,
  output logic [EW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [SW-1:0] wr_addr,
  input  logic [EW-1:0] wr_data
);

  logic [EW-1:0]         mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] written;
  logic [EW-1:0]         mem_q;
  logic                  hit_q;
  logic [SW-1:0]         addr_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q  <= mem[rd_addr];
      addr_q <= rd_addr;
    end
  end

  // an entry never written reads as its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_q <= written[rd_addr];
      end
    end
  end

  always_comb begin
    if (hit_q) begin
      rd_data = mem_q;
    end else if (addr_q == '0) begin
      rd_data = {ST_RUNNING, {(EW-3){1'b0}}};
    end else begin
      rd_data = {ST_EMPTY, {(EW-3){1'b0}}};
    end
  end

endmodule

FILE: sv/rrs_ctrl.sv
module rrs_ctrl
  import rrs_pkg::*;
#(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS,
  parameter int SLEEP_BITS = DEF_SLEEP_BITS,
  localparam int SW        = $clog2(TASK_SLOTS),
  localparam int EW        = SLEEP_BITS + 11
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_t           in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data,
  output logic          rd_en,
  output logic [SW-1:0] rd_addr,
  input  logic [EW-1:0] rd_data,
  output logic          wr_en,
  output logic [SW-1:0] wr_addr,
  output logic [EW-1:0] wr_data
);

  localparam logic [SW:0]   NSLOT = (SW+1)'(TASK_SLOTS);
  localparam logic [SW:0]   NLAST = (SW+1)'(TASK_SLOTS - 1);
  localparam logic [SW-1:0] ALAST = SW'(TASK_SLOTS - 1);

  fsm_t                  state, state_next;
  logic [2:0]            op_r, op_r_next;
  logic [SW-1:0]         idx_r, idx_r_next;
  logic [SLEEP_BITS-1:0] ms_r, ms_r_next;
  logic [SW-1:0]         before_r, before_r_next;
  logic [SW-1:0]         cur, cur_next;
  logic [15:0]           phase, phase_next;
  logic [1:0]            status_r, status_r_next;
  logic [SW-1:0]         created_r, created_r_next;
  logic [SW:0]           cnt, cnt_next;
  logic [SW-1:0]         sidx, sidx_next;
  logic                  p_vld, p_vld_next;
  logic [SW-1:0]         p_addr, p_addr_next;
  logic                  p_last, p_last_next;
  logic                  out_valid_next;
  out_t                  out_data_next;

  logic [2:0]            e_st;
  logic [SLEEP_BITS-1:0] e_sl;
  logic [7:0]            e_rc;
  logic [15:0]           phase_inc;
  logic [SW-1:0]         cur_inc;

  assign e_st      = rd_data[EW-1 -: 3];
  assign e_sl      = rd_data[8 +: SLEEP_BITS];
  assign e_rc      = rd_data[7:0];
  assign phase_inc = phase + 16'd1;
  assign cur_inc   = (cur == ALAST) ? '0 : cur + 1'b1;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      phase     <= '0;
      p_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur       <= cur_next;
      phase     <= phase_next;
      p_vld     <= p_vld_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_r_next;
    idx_r     <= idx_r_next;
    ms_r      <= ms_r_next;
    before_r  <= before_r_next;
    status_r  <= status_r_next;
    created_r <= created_r_next;
    cnt       <= cnt_next;
    sidx      <= sidx_next;
    p_addr    <= p_addr_next;
    p_last    <= p_last_next;
    out_data  <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    op_r_next      = op_r;
    idx_r_next     = idx_r;
    ms_r_next      = ms_r;
    before_r_next  = before_r;
    cur_next       = cur;
    phase_next     = phase;
    status_r_next  = status_r;
    created_r_next = created_r;
    cnt_next       = cnt;
    sidx_next      = sidx;
    p_vld_next     = 1'b0;
    p_addr_next    = p_addr;
    p_last_next    = p_last;
    out_valid_next = out_valid & out_stall;
    out_data_next  = out_data;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = p_addr;
    wr_data        = rd_data;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r_next      = in_data.opcode;
          ms_r_next      = SLEEP_BITS'(in_data.sleep_ticks);
          idx_r_next     = SW'(in_data.task_index);
          before_r_next  = cur;
          status_r_next  = STS_OK;
          created_r_next = '0;
          cnt_next       = '0;
          if ((in_data.opcode inside {[OP_BLOCK:OP_KILL]}) &&
              (32'(in_data.task_index) >= TASK_SLOTS)) begin
            status_r_next = STS_BADIDX;
            state_next    = S_DONE;
          end else begin
            case (in_data.opcode)
              OP_TICK:   state_next = cfg.enable ? S_SWEEP : S_DONE;
              OP_CREATE: state_next = S_CSCAN;
              OP_BLOCK, OP_SLEEP, OP_UNBLOCK, OP_KILL: state_next = S_RD;
              OP_REAP:   state_next = S_SWEEP;
              default:   state_next = S_DONE;
            endcase
          end
        end
      end

      // walk every slot: read one, write back the one read last cycle
      S_SWEEP: begin
        if (cnt < NSLOT) begin
          rd_en       = 1'b1;
          rd_addr     = cnt[SW-1:0];
          p_vld_next  = 1'b1;
          p_addr_next = cnt[SW-1:0];
          p_last_next = (cnt == NLAST);
          cnt_next    = cnt + 1'b1;
        end
        if (p_vld) begin
          wr_en = 1'b1;
          if (op_r == OP_TICK) begin
            if (e_st == ST_SLEEPING) begin
              if (e_sl <= SLEEP_BITS'(1)) begin
                wr_data = {ST_READY, {SLEEP_BITS{1'b0}}, e_rc};
              end else begin
                wr_data = {e_st, e_sl - SLEEP_BITS'(1), e_rc};
              end
            end
          end else if (e_st == ST_KILLED) begin
            wr_data = {ST_EMPTY, e_sl, e_rc};
          end
          if (p_last) begin
            if (op_r == OP_TICK) begin
              if (phase_inc < cfg.quantum_ticks) begin
                phase_next = phase_inc;
                state_next = S_DONE;
              end else begin
                phase_next = '0;
                state_next = S_QRD;
              end
            end else begin
              state_next = S_DONE;
            end
          end
        end
      end

      S_QRD: begin
        rd_en      = 1'b1;
        rd_addr    = cur;
        state_next = S_QWR;
      end

      S_QWR: begin
        wr_en   = 1'b1;
        wr_addr = cur;
        if (e_rc != cfg.turnover_rounds) begin
          wr_data    = {e_st, e_sl, e_rc + 8'd1};
          state_next = S_DONE;
        end else begin
          wr_data    = {ST_READY, e_sl, 8'd0};
          cnt_next   = (SW+1)'(1);
          sidx_next  = cur_inc;
          state_next = S_RSCAN;
        end
      end

      S_CSCAN: begin
        if (cnt < NSLOT) begin
          rd_en       = 1'b1;
          rd_addr     = cnt[SW-1:0];
          p_vld_next  = 1'b1;
          p_addr_next = cnt[SW-1:0];
          p_last_next = (cnt == NLAST);
          cnt_next    = cnt + 1'b1;
        end
        if (p_vld) begin
          if (e_st == ST_EMPTY) begin
            wr_en          = 1'b1;
            wr_data        = {ST_READY, {SLEEP_BITS{1'b0}}, 8'd0};
            created_r_next = p_addr;
            state_next     = S_DONE;
          end else if (p_last) begin
            status_r_next = STS_NOSLOT;
            state_next    = S_DONE;
          end
        end
      end

      S_RD: begin
        rd_en      = 1'b1;
        rd_addr    = idx_r;
        state_next = S_WR;
      end

      S_WR: begin
        wr_addr   = idx_r;
        cnt_next  = (SW+1)'(1);
        sidx_next = cur_inc;
        state_next = (idx_r == cur) ? S_RSCAN : S_DONE;
        case (op_r)
          OP_BLOCK: begin
            wr_en   = 1'b1;
            wr_data = {ST_BLOCKED, e_sl, e_rc};
          end
          OP_SLEEP: begin
            wr_en   = 1'b1;
            wr_data = {ST_SLEEPING, ms_r, e_rc};
          end
          OP_KILL: begin
            wr_en   = 1'b1;
            wr_data = {ST_KILLED, e_sl, e_rc};
          end
          default: begin
            state_next = S_DONE;
            if (e_st == ST_BLOCKED || e_st == ST_WAITING) begin
              wr_en   = 1'b1;
              wr_data = {ST_READY, e_sl, e_rc};
            end
          end
        endcase
      end

      // cyclic search after the current slot, idle excluded
      S_RSCAN: begin
        if (cnt < NSLOT) begin
          rd_en       = 1'b1;
          rd_addr     = sidx;
          p_vld_next  = 1'b1;
          p_addr_next = sidx;
          p_last_next = (cnt == NLAST);
          cnt_next    = cnt + 1'b1;
          sidx_next   = (sidx == ALAST) ? '0 : sidx + 1'b1;
        end
        if (p_vld) begin
          if (p_addr != '0 && e_st == ST_READY) begin
            wr_en      = 1'b1;
            wr_data    = {ST_RUNNING, e_sl, e_rc};
            cur_next   = p_addr;
            state_next = S_DONE;
          end else if (p_last) begin
            state_next = S_RS0;
          end
        end
      end

      S_RS0: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        state_next = S_RS0W;
      end

      S_RS0W: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = {ST_RUNNING, e_sl, e_rc};
        cur_next   = '0;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next             = 1'b1;
          out_data_next.running_task = 4'(cur);
          out_data_next.switched     = (cur != before_r);
          out_data_next.created_task = 4'(created_r);
          out_data_next.status       = status_r;
          state_next                 = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: sv/round_robin_task_scheduler_top.sv
// Work per item: a disabled tick, bad index or unknown opcode only answers;
//   block/sleep/unblock/kill update one slot, and search for a ready slot
//   when the running slot must be replaced; create scans for a free slot;
//   tick and reap walk every slot, and a preempting tick then searches too.
//   One item is in work at a time; the single read port walks one slot per cycle.
// Reset: synchronous, active high; the slot table needs no clearing pass.
module round_robin_task_scheduler_top
  import rrs_pkg::*;
#(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS,
  parameter int SLEEP_BITS = DEF_SLEEP_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam int EW = SLEEP_BITS + 11;

  cfg_t          cfg;
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // Configuration registers: a transfer lands every cycle, writes beyond
  // the register list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b0;
      cfg.quantum_ticks   <= 16'd10;
      cfg.turnover_rounds <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE:   cfg.enable          <= cfg_data[0];
        CFG_QUANTUM:  cfg.quantum_ticks   <= cfg_data;
        CFG_TURNOVER: cfg.turnover_rounds <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer: takes one transfer, walks the slot table through the
  // memory port, and holds the result in its output register, so the
  // next item may enter while the last result still waits.
  rrs_ctrl #(
    .TASK_SLOTS (TASK_SLOTS),
    .SLEEP_BITS (SLEEP_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Slot table: state, sleep countdown and round count of every slot,
  // one entry per slot, read data registered.
  rrs_mem #(
    .TASK_SLOTS (TASK_SLOTS),
    .EW         (EW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

FILE: sv/rrs_chk.sv
module rrs_chk
  import rrs_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == STS_OK || out_data.status == STS_NOSLOT ||
                  out_data.status == STS_BADIDX)
    else $error("undefined status");

  a_created_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.created_task != 4'd0 |-> out_data.status == STS_OK)
    else $error("slot given with failing status");

  a_bad_no_switch: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STS_BADIDX |-> !out_data.switched)
    else $error("rejected operation switched task");

endmodule

bind round_robin_task_scheduler_top rrs_chk u_chk (.*);

FILE: test/tb.sv
module tb;
  import rrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  round_robin_task_scheduler_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Scheduler shadow: configuration and slot table as the block should hold them
  logic        sh_enable;
  logic [15:0] sh_quantum;
  logic [7:0]  sh_turnover;
  logic [2:0]  sh_state [NSLOT];
  logic [31:0] sh_sleep [NSLOT];
  logic [7:0]  sh_rounds [NSLOT];
  logic [3:0]  sh_current;
  logic [15:0] sh_phase;

  in_t  pending_ops [$];
  out_t expected_results [$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   switches_seen = 0;
  int   wdog = 0;
  bit   quiet_tail = 1'b0;
  bit   stim_done = 1'b0;

  function automatic void shadow_reset();
    sh_enable = 1'b0;
    sh_quantum = 16'd10;
    sh_turnover = 8'd3;
    for (int i = 0; i < NSLOT; i++) begin
      sh_state[i] = ST_EMPTY;
      sh_sleep[i] = '0;
      sh_rounds[i] = '0;
    end
    sh_state[0] = ST_RUNNING;
    sh_current = '0;
    sh_phase = '0;
  endfunction

  function automatic void shadow_config(logic [1:0] idx, logic [15:0] val);
    case (idx)
      CFG_ENABLE: sh_enable = val[0];
      CFG_QUANTUM: sh_quantum = val;
      CFG_TURNOVER: sh_turnover = val[7:0];
      default: ;
    endcase
  endfunction

  // Pick the next ready slot after the current one, never idle, else idle
  function automatic void reschedule();
    logic [3:0] s;
    logic [3:0] pick;
    if (sh_state[sh_current] == ST_RUNNING) return;
    pick = '0;
    for (int i = 1; i < NSLOT; i++) begin
      s = sh_current + 4'(i);
      if (pick == 0 && s != 0 && sh_state[s] == ST_READY) pick = s;
    end
    sh_current = pick;
    sh_state[pick] = ST_RUNNING;
  endfunction

  function automatic void tick_step();
    if (!sh_enable) return;
    for (int i = 0; i < NSLOT; i++) begin
      if (sh_state[i] == ST_SLEEPING) begin
        if (sh_sleep[i] <= 1) begin
          sh_sleep[i] = '0;
          sh_state[i] = ST_READY;
        end else begin
          sh_sleep[i] = sh_sleep[i] - 1;
        end
      end
    end
    sh_phase = sh_phase + 16'd1;
    if (sh_phase < sh_quantum) return;
    sh_phase = '0;
    if (sh_rounds[sh_current] != sh_turnover) begin
      sh_rounds[sh_current] = sh_rounds[sh_current] + 8'd1;
      return;
    end
    sh_rounds[sh_current] = '0;
    sh_state[sh_current] = ST_READY;
    reschedule();
  endfunction

  function automatic out_t schedule_op(in_t op);
    out_t r;
    logic [3:0] prev;
    int found;
    prev = sh_current;
    r = '0;
    r.status = STS_OK;
    case (op.opcode)
      OP_TICK: tick_step();
      OP_CREATE: begin
        found = -1;
        for (int i = 0; i < NSLOT; i++)
          if (found < 0 && sh_state[i] == ST_EMPTY) found = i;
        if (found < 0) begin
          r.status = STS_NOSLOT;
        end else begin
          sh_state[found] = ST_READY;
          sh_rounds[found] = '0;
          sh_sleep[found] = '0;
          r.created_task = 4'(found);
        end
      end
      OP_BLOCK: begin
        sh_state[op.task_index] = ST_BLOCKED;
        reschedule();
      end
      OP_SLEEP: begin
        sh_state[op.task_index] = ST_SLEEPING;
        sh_sleep[op.task_index] = op.sleep_ticks;
        reschedule();
      end
      OP_UNBLOCK: begin
        if (sh_state[op.task_index] == ST_BLOCKED || sh_state[op.task_index] == ST_WAITING)
          sh_state[op.task_index] = ST_READY;
      end
      OP_KILL: begin
        sh_state[op.task_index] = ST_KILLED;
        reschedule();
      end
      OP_REAP: begin
        for (int i = 0; i < NSLOT; i++)
          if (sh_state[i] == ST_KILLED) sh_state[i] = ST_EMPTY;
      end
      default: ;
    endcase
    r.running_task = sh_current;
    r.switched = (sh_current != prev);
    return r;
  endfunction

  // Driver: present the head of the pending queue, with random idle bursts
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(schedule_op(in_data));
        void'(pending_ops.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer as it is
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 11) - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        in_data <= pending_ops[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, then compare each transfer with the oldest prediction
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          out_t e;
          e = expected_results.pop_front();
          if (e.switched) switches_seen++;
          if (out_data !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected run=%0d sw=%0d cr=%0d st=%0d, ",
                        "got run=%0d sw=%0d cr=%0d st=%0d"},
                       e.running_task, e.switched, e.created_task, e.status,
                       out_data.running_task, out_data.switched, out_data.created_task,
                       out_data.status);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || rst)
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("[round_robin_task_scheduler_top] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_config(idx, val);
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (2 * NSLOT + 12) @(posedge clk);
  endtask

  function automatic in_t make_op(logic [2:0] opc, logic [3:0] idx, logic [31:0] ticks);
    in_t t;
    t.opcode = opc;
    t.task_index = idx;
    t.sleep_ticks = ticks;
    return t;
  endfunction

  // Random item: mostly well-formed, with ticks dominating so sleeps and quanta expire
  function automatic in_t random_op();
    int r;
    logic [31:0] ticks;
    r = $urandom_range(0, 99);
    ticks = ($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(0, 6));
    if (r < 45) return make_op(OP_TICK, '0, $urandom());
    if (r < 57) return make_op(OP_CREATE, 4'($urandom()), $urandom());
    if (r < 65) return make_op(OP_BLOCK, 4'($urandom()), $urandom());
    if (r < 75) return make_op(OP_SLEEP, 4'($urandom()), ticks);
    if (r < 85) return make_op(OP_UNBLOCK, 4'($urandom()), $urandom());
    if (r < 91) return make_op(OP_KILL, 4'($urandom()), $urandom());
    if (r < 97) return make_op(OP_REAP, 4'($urandom()), $urandom());
    return make_op(3'd7, 4'($urandom()), $urandom());
  endfunction

  initial begin
    shadow_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: disabled tick, creates to exhaustion, block, unblock, kill, reap, unknown code
    pending_ops.push_back(make_op(OP_TICK, '0, '0));
    for (int i = 0; i < 16; i++) pending_ops.push_back(make_op(OP_CREATE, '0, '0));
    pending_ops.push_back(make_op(OP_BLOCK, 4'd15, 32'hFFFF_FFFF));
    pending_ops.push_back(make_op(OP_UNBLOCK, 4'd15, '0));
    pending_ops.push_back(make_op(OP_KILL, 4'd3, '0));
    pending_ops.push_back(make_op(OP_REAP, '0, '0));
    pending_ops.push_back(make_op(3'd7, 4'd9, 32'h5A5A_A5A5));
    drain();

    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_QUANTUM, 16'd1);
    write_reg(CFG_TURNOVER, 16'd0);
    // Zero-tick sleep, preemption every tick, sleep of the idle slot
    pending_ops.push_back(make_op(OP_SLEEP, 4'd0, '0));
    pending_ops.push_back(make_op(OP_TICK, '0, '0));
    pending_ops.push_back(make_op(OP_SLEEP, 4'd5, '0));
    pending_ops.push_back(make_op(OP_TICK, '0, '0));
    pending_ops.push_back(make_op(OP_TICK, '0, '0));
    pending_ops.push_back(make_op(OP_KILL, 4'd0, '0));
    pending_ops.push_back(make_op(OP_REAP, '0, '0));
    drain();

    // Random phases across several settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_QUANTUM, 16'd2); write_reg(CFG_TURNOVER, 16'd1); end
        1: begin write_reg(CFG_QUANTUM, 16'hFFFF); write_reg(CFG_TURNOVER, 16'd255); end
        2: begin write_reg(CFG_QUANTUM, 16'd0); write_reg(CFG_TURNOVER, 16'd0); end
        3: write_reg(CFG_ENABLE, 16'd0);
        4: begin write_reg(CFG_ENABLE, 16'hFFFF);
                 write_reg(CFG_QUANTUM, 16'd3); write_reg(CFG_TURNOVER, 16'hFF02); end
        default: begin write_reg(CFG_QUANTUM, 16'd1); write_reg(CFG_TURNOVER, 16'd3); end
      endcase
      if (ph == 5) quiet_tail = 1'b1;
      for (int k = 0; k < 155; k++) pending_ops.push_back(random_op());
      drain();
    end

    $display("covered %0d results, %0d task switches, six configuration phases",
             results_seen, switches_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[round_robin_task_scheduler_top] OK");
    end else begin
      $display("[round_robin_task_scheduler_top] ERROR");
    end
    $finish;
  end

endmodule
